// File: sv/vcsd_pkg.sv
`timescale 1ns / 1ps

package vcsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CoordW = 15;
  localparam int unsigned IntenW = 7;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CountW = LenW + 1;
  localparam int unsigned ItemW  = 9;

  // frame parser phases
  localparam logic [1:0] PhLenHi = 2'd0;
  localparam logic [1:0] PhLenLo = 2'd1;
  localparam logic [1:0] PhCmd   = 2'd2;
  localparam logic [1:0] PhOper  = 2'd3;

  // command codes after masking
  localparam logic [ByteW-1:0] CmdBright   = 8'h10;
  localparam logic [ByteW-1:0] CmdDot      = 8'h20;
  localparam logic [ByteW-1:0] CmdLine     = 8'h30;
  localparam logic [ByteW-1:0] CmdEnd      = 8'h70;
  localparam logic [ByteW-1:0] CmdDots     = 8'h80;
  localparam logic [ByteW-1:0] CmdPath     = 8'hA0;
  localparam logic [ByteW-1:0] CmdPathNext = 8'hC0;
  localparam logic [ByteW-1:0] CmdLines    = 8'hE0;

  localparam logic [ByteW-1:0] CountedMask = 8'hE0;
  localparam logic [ByteW-1:0] SimpleMask  = 8'hF0;

  localparam logic [IntenW-1:0] IntenReset = 7'h7F;

  // signed byte times 128
  function automatic logic signed [CoordW-1:0] scale_coord(input logic [ByteW-1:0] b);
    scale_coord = {b, 7'd0};
  endfunction

endpackage

// File: sv/vector_command_stream_decoder.sv
`timescale 1ns / 1ps

// Vector command stream decoder.
// Input channel: one frame byte per transfer on data_byte_i (in_valid_i / in_stall_o).
// A frame is a two-byte length, high byte first, then command and coordinate bytes.
// Output channel: one result per transfer (out_valid_o / out_stall_i), carrying a
// segment, a frame-done flag with its reason, or both. Bytes that finish nothing
// give no result.
// A taken byte goes through the input register, the decode logic and the result
// register before its result is presented on the output channel.
// Throughput: one byte per cycle while in_stall_o is low, set by the single decode
// stage between the input register and the result register.
// While the result register is full and stalled, bytes that give no result still
// go through the decoder; the first byte that gives a result waits in the input
// register and in_stall_o goes high.
// Reset clears both registers and the parser: it waits for a length high byte,
// with brightness at full scale (127).
module vector_command_stream_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [vcsd_pkg::ByteW-1:0]          data_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                segment_valid_o,
  output logic signed [vcsd_pkg::CoordW-1:0]  start_x_o,
  output logic signed [vcsd_pkg::CoordW-1:0]  start_y_o,
  output logic signed [vcsd_pkg::CoordW-1:0]  end_x_o,
  output logic signed [vcsd_pkg::CoordW-1:0]  end_y_o,
  output logic [vcsd_pkg::IntenW-1:0]         intensity_o,
  output logic                                frame_done_o,
  output logic                                done_reason_o
);
  import vcsd_pkg::*;

  // input register
  logic              in_vld_q;
  logic [ByteW-1:0]  byte_q;

  // parser state
  logic [1:0]        ph_q, ph_d;
  logic [ByteW-1:0]  lh_q, lh_d;
  logic [LenW-1:0]   fl_q, fl_d;
  logic [CountW-1:0] bc_q, bc_d;
  logic [ByteW-1:0]  cc_q, cc_d;
  logic [ItemW-1:0]  il_q, il_d;
  logic [1:0]        oi_q, oi_d;
  logic [ByteW-1:0]  cr_q [4];
  logic [ByteW-1:0]  cr_d [4];
  logic [IntenW-1:0] br_q, br_d;

  // result register
  logic                     out_vld_q;
  logic                     seg_q, done_q, reason_q;
  logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [IntenW-1:0]        inten_q;

  // decode outputs
  logic             seg, done, reason;
  logic [ByteW-1:0] sx, sy, ex, ey;
  logic             has_res;
  logic             advance;
  logic             out_free;

  logic [CountW-1:0] bc_inc;
  logic [ByteW-1:0]  cmd;
  logic [ItemW-1:0]  n_items;
  logic [ItemW-1:0]  il_dec;
  logic [1:0]        last_idx;
  logic              two_coord;

  always_comb begin
    bc_inc = (bc_q != {CountW{1'b1}}) ? bc_q + CountW'(1) : bc_q;
    if (byte_q[7]) begin
      cmd     = byte_q & CountedMask;
      n_items = (byte_q[4:0] == 5'd0) ? ItemW'(256) : ItemW'(byte_q[4:0]);
    end else begin
      cmd     = byte_q & SimpleMask;
      n_items = ItemW'(1);
    end
    il_dec    = (il_q != '0) ? il_q - ItemW'(1) : '0;
    two_coord = cc_q inside {CmdDot, CmdDots, CmdPathNext};
    last_idx  = two_coord ? 2'd1 : 2'd3;
  end

  always_comb begin
    ph_d   = ph_q;
    lh_d   = lh_q;
    fl_d   = fl_q;
    bc_d   = bc_q;
    cc_d   = cc_q;
    il_d   = il_q;
    oi_d   = oi_q;
    cr_d   = cr_q;
    br_d   = br_q;
    seg    = 1'b0;
    done   = 1'b0;
    reason = 1'b0;
    sx     = '0;
    sy     = '0;
    ex     = '0;
    ey     = '0;
    case (ph_q)
      PhLenHi: begin
        lh_d = byte_q;
        ph_d = PhLenLo;
      end
      PhLenLo: begin
        fl_d = {lh_q, byte_q};
        bc_d = '0;
        oi_d = '0;
        il_d = '0;
        if ({lh_q, byte_q} == '0) begin
          done   = 1'b1;
          reason = 1'b1;
          ph_d   = PhLenHi;
        end else begin
          ph_d = PhCmd;
        end
      end
      PhCmd: begin
        bc_d = bc_inc;
        case (cmd)
          CmdBright: br_d = {byte_q[3:0], 3'd0};
          CmdDot, CmdLine, CmdDots, CmdLines, CmdPath: begin
            cc_d = cmd;
            il_d = n_items;
            oi_d = '0;
            ph_d = PhOper;
          end
          CmdEnd: begin
            done = 1'b1;
            ph_d = PhLenHi;
          end
          default: ;
        endcase
        if (ph_d == PhCmd && bc_inc >= CountW'(fl_q)) begin
          done   = 1'b1;
          reason = 1'b1;
          ph_d   = PhLenHi;
        end
      end
      default: begin
        // operand bytes
        bc_d       = bc_inc;
        cr_d[oi_q] = byte_q;
        if (oi_q != last_idx) begin
          oi_d = oi_q + 2'd1;
        end else begin
          oi_d = '0;
          seg  = 1'b1;
          if (cc_q == CmdDot || cc_q == CmdDots) begin
            sx = cr_q[0];
            sy = byte_q;
            ex = cr_q[0];
            ey = byte_q;
          end else if (cc_q == CmdPathNext) begin
            sx      = cr_q[2];
            sy      = cr_q[3];
            ex      = cr_q[0];
            ey      = byte_q;
            cr_d[2] = cr_q[0];
            cr_d[3] = byte_q;
          end else begin
            sx = cr_q[0];
            sy = cr_q[1];
            ex = cr_q[2];
            ey = byte_q;
            if (cc_q == CmdPath) cc_d = CmdPathNext;
          end
          il_d = il_dec;
          if (il_dec == '0) begin
            ph_d = PhCmd;
            if (bc_inc >= CountW'(fl_q)) begin
              done   = 1'b1;
              reason = 1'b1;
              ph_d   = PhLenHi;
            end
          end
        end
      end
    endcase
  end

  // bytes without a result never wait on the output side
  assign has_res    = seg | done;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (out_free || !has_res);
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PhLenHi;
      lh_q  <= '0;
      fl_q  <= '0;
      bc_q  <= '0;
      cc_q  <= '0;
      il_q  <= '0;
      oi_q  <= '0;
      cr_q  <= '{default: '0};
      br_q  <= IntenReset;
    end else if (advance) begin
      ph_q  <= ph_d;
      lh_q  <= lh_d;
      fl_q  <= fl_d;
      bc_q  <= bc_d;
      cc_q  <= cc_d;
      il_q  <= il_d;
      oi_q  <= oi_d;
      cr_q  <= cr_d;
      br_q  <= br_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && has_res) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_res) begin
      seg_q    <= seg;
      done_q   <= done;
      reason_q <= reason;
      sx_q     <= scale_coord(sx);
      sy_q     <= scale_coord(sy);
      ex_q     <= scale_coord(ex);
      ey_q     <= scale_coord(ey);
      inten_q  <= seg ? br_q : '0;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign segment_valid_o = seg_q;
  assign start_x_o       = sx_q;
  assign start_y_o       = sy_q;
  assign end_x_o         = ex_q;
  assign end_y_o         = ey_q;
  assign intensity_o     = inten_q;
  assign frame_done_o    = done_q;
  assign done_reason_o   = reason_q;

endmodule

// File: dv/tb_vector_command_stream_decoder.sv
`timescale 1ns / 1ps

import vcsd_pkg::*;

typedef struct packed {
  logic              seg;
  logic [CoordW-1:0] sx;
  logic [CoordW-1:0] sy;
  logic [CoordW-1:0] ex;
  logic [CoordW-1:0] ey;
  logic [IntenW-1:0] inten;
  logic              done;
  logic              reason;
} draw_result_t;

class draw_list_checker;
  // decoder state
  logic [1:0]        phase;
  logic [ByteW-1:0]  len_hi;
  logic [LenW-1:0]   frame_len;
  logic [CountW-1:0] consumed;
  logic [ByteW-1:0]  cur_cmd;
  logic [ItemW-1:0]  items_left;
  logic [1:0]        op_idx;
  logic [ByteW-1:0]  coord[4];
  logic [IntenW-1:0] bright;

  draw_result_t expected_draws[$];
  int unsigned  mismatches;
  int unsigned  checked;
  int unsigned  segments;
  int unsigned  closes;

  function new();
    phase      = PhLenHi;
    len_hi     = '0;
    frame_len  = '0;
    consumed   = '0;
    cur_cmd    = '0;
    items_left = '0;
    op_idx     = '0;
    foreach (coord[i]) coord[i] = '0;
    bright     = IntenReset;
    mismatches = 0;
    checked    = 0;
    segments   = 0;
    closes     = 0;
  endfunction

  function int unsigned pending();
    return expected_draws.size();
  endfunction

  // returns 1 when the byte produces a result
  function bit decode_byte(input logic [ByteW-1:0] b, output draw_result_t r);
    logic [ByteW-1:0] cmd;
    logic [ItemW-1:0] count;
    logic [ByteW-1:0] sx, sy, ex, ey;
    int               need;
    bit               seg, done, why;
    seg = 1'b0;
    done = 1'b0;
    why = 1'b0;
    sx = '0;
    sy = '0;
    ex = '0;
    ey = '0;
    r = '0;
    case (phase)
      PhLenHi: begin
        len_hi = b;
        phase = PhLenLo;
      end
      PhLenLo: begin
        frame_len = {len_hi, b};
        consumed = '0;
        op_idx = '0;
        items_left = '0;
        if (frame_len == 0) begin
          done = 1'b1;
          why = 1'b1;
          phase = PhLenHi;
        end else begin
          phase = PhCmd;
        end
      end
      PhCmd: begin
        if (consumed != '1) consumed++;
        if (b[7]) begin
          cmd = b & CountedMask;
          count = (b[4:0] == 5'd0) ? ItemW'(256) : ItemW'(b[4:0]);
        end else begin
          cmd = b & SimpleMask;
          count = ItemW'(1);
        end
        case (cmd)
          CmdBright: bright = {b[3:0], 3'b000};
          CmdDot, CmdLine, CmdDots, CmdLines, CmdPath: begin
            cur_cmd = cmd;
            items_left = count;
            op_idx = '0;
            phase = PhOper;
          end
          CmdEnd: begin
            done = 1'b1;
            why = 1'b0;
            phase = PhLenHi;
          end
          default: ;
        endcase
        if (phase == PhCmd && consumed >= CountW'(frame_len)) begin
          done = 1'b1;
          why = 1'b1;
          phase = PhLenHi;
        end
      end
      default: begin
        need = (cur_cmd == CmdDot || cur_cmd == CmdDots || cur_cmd == CmdPathNext) ? 2 : 4;
        if (consumed != '1) consumed++;
        coord[op_idx] = b;
        if (int'(op_idx) + 1 < need) begin
          op_idx++;
        end else begin
          op_idx = '0;
          seg = 1'b1;
          if (cur_cmd == CmdDot || cur_cmd == CmdDots) begin
            sx = coord[0];
            ex = coord[0];
            sy = coord[1];
            ey = coord[1];
          end else if (cur_cmd == CmdPathNext) begin
            // path continues from the previous end point
            sx = coord[2];
            sy = coord[3];
            ex = coord[0];
            ey = coord[1];
            coord[2] = coord[0];
            coord[3] = coord[1];
          end else begin
            sx = coord[0];
            sy = coord[1];
            ex = coord[2];
            ey = coord[3];
            if (cur_cmd == CmdPath) cur_cmd = CmdPathNext;
          end
          if (items_left != 0) items_left--;
          if (items_left == 0) begin
            phase = PhCmd;
            if (consumed >= CountW'(frame_len)) begin
              done = 1'b1;
              why = 1'b1;
              phase = PhLenHi;
            end
          end
        end
      end
    endcase
    if (seg) begin
      r.seg = 1'b1;
      r.sx = {sx, 7'd0};
      r.sy = {sy, 7'd0};
      r.ex = {ex, 7'd0};
      r.ey = {ey, 7'd0};
      r.inten = bright;
    end
    if (done) begin
      r.done = 1'b1;
      r.reason = why;
    end
    return seg || done;
  endfunction

  function void note_byte(input logic [ByteW-1:0] b);
    draw_result_t r;
    if (decode_byte(b, r)) begin
      expected_draws.push_back(r);
      if (r.seg) segments++;
      if (r.done) closes++;
    end
  endfunction

  task report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task compare_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task check_result(input draw_result_t got);
    draw_result_t want;
    if (expected_draws.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending (seg %0b done %0b)",
                                got.seg, got.done));
      return;
    end
    want = expected_draws.pop_front();
    checked++;
    compare_field("segment_valid", got.seg, want.seg);
    compare_field("start_x", $signed(got.sx), $signed(want.sx));
    compare_field("start_y", $signed(got.sy), $signed(want.sy));
    compare_field("end_x", $signed(got.ex), $signed(want.ex));
    compare_field("end_y", $signed(got.ey), $signed(want.ey));
    compare_field("intensity", got.inten, want.inten);
    compare_field("frame_done", got.done, want.done);
    compare_field("done_reason", got.reason, want.reason);
  endtask
endclass

module tb_vector_command_stream_decoder;

  logic             clk_i = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic [ByteW-1:0] data_byte = '0;
  logic             out_stall = 1'b0;

  logic                     in_stall_o;
  logic                     out_valid_o;
  logic                     segment_valid_o;
  logic signed [CoordW-1:0] start_x_o;
  logic signed [CoordW-1:0] start_y_o;
  logic signed [CoordW-1:0] end_x_o;
  logic signed [CoordW-1:0] end_y_o;
  logic [IntenW-1:0]        intensity_o;
  logic                     frame_done_o;
  logic                     done_reason_o;

  draw_list_checker sb = new();
  // tracks the stream as driven, so frames can be closed cleanly
  draw_list_checker shadow = new();

  logic [ByteW-1:0] frame_body[$];
  bit               quiet = 1'b0;
  int unsigned      bytes_sent = 0;
  int unsigned      frames_sent = 0;
  int unsigned      stall_hold = 0;

  vector_command_stream_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .segment_valid_o(segment_valid_o),
    .start_x_o      (start_x_o),
    .start_y_o      (start_y_o),
    .end_x_o        (end_x_o),
    .end_y_o        (end_y_o),
    .intensity_o    (intensity_o),
    .frame_done_o   (frame_done_o),
    .done_reason_o  (done_reason_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold = pick_gap();
    end
  end

  // transfer monitor on both channels
  always @(posedge clk_i) begin
    draw_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall_o) sb.note_byte(data_byte);
      if (out_valid_o && !out_stall) begin
        got.seg = segment_valid_o;
        got.sx = start_x_o;
        got.sy = start_y_o;
        got.ex = end_x_o;
        got.ey = end_y_o;
        got.inten = intensity_o;
        got.done = frame_done_o;
        got.reason = done_reason_o;
        sb.check_result(got);
      end
    end
  end

  function automatic logic [ByteW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 8'h80;
      1: return 8'h7F;
      2: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_coords(input int unsigned n);
    repeat (n) frame_body.push_back(rand_coord());
  endfunction

  function automatic logic [4:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r == 0) return 5'd0;
    if (r < 80) return 5'($urandom_range(1, 4));
    return 5'($urandom_range(5, 31));
  endfunction

  function automatic void add_command();
    logic [4:0]  n;
    int unsigned items;
    n = pick_count();
    items = (n == 0) ? 256 : n;
    case ($urandom_range(0, 7))
      0: frame_body.push_back(CmdBright | 8'($urandom_range(0, 15)));
      1: begin
        frame_body.push_back(CmdDot | 8'($urandom_range(0, 15)));
        push_coords(2);
      end
      2: begin
        frame_body.push_back(CmdLine | 8'($urandom_range(0, 15)));
        push_coords(4);
      end
      3: begin
        frame_body.push_back(CmdDots | 8'(n));
        push_coords(2 * items);
      end
      4: begin
        frame_body.push_back(CmdLines | 8'(n));
        push_coords(4 * items);
      end
      5, 6: begin
        frame_body.push_back(CmdPath | 8'(n));
        push_coords(4 + 2 * (items - 1));
      end
      default: begin
        // codes the decoder skips
        case ($urandom_range(0, 2))
          0: frame_body.push_back(8'($urandom_range(8'h00, 8'h0F)));
          1: frame_body.push_back(8'($urandom_range(8'h40, 8'h6F)));
          default: frame_body.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        endcase
      end
    endcase
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned  gap;
    draw_result_t unused;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    void'(shadow.decode_byte(b, unused));
    bytes_sent++;
  endtask

  // header, then body bytes until the frame closes; pads if the body runs out
  task automatic send_frame(input logic [LenW-1:0] len);
    int unsigned idx;
    idx = 0;
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    while (shadow.phase != PhLenHi) begin
      if (idx < frame_body.size()) begin
        send_byte(frame_body[idx]);
        idx++;
      end else if (shadow.phase == PhCmd) begin
        send_byte(CmdEnd | 8'($urandom_range(0, 15)));
      end else begin
        send_byte(rand_coord());
      end
    end
    frames_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned      kind;
    int unsigned      n;
    logic [LenW-1:0]  len;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // zero length closes on the low byte
    frame_body.delete();
    send_frame(16'h0000);

    // long frame closed by end-list, every command kind but path, extreme coordinates
    frame_body = '{8'h1F, 8'h2A, 8'h80, 8'h7F, 8'h3F, 8'h7F, 8'h80, 8'h00, 8'hFF,
                   8'h81, 8'h01, 8'hFE, 8'h10, 8'hE1, 8'hFF, 8'h00, 8'h80, 8'h7F,
                   8'h4A, 8'h70};
    send_frame(16'hFFFF);

    // length runs out inside a path; last coordinate closes the frame too
    frame_body = '{8'hA2, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60};
    send_frame(16'h0001);

    drain();

    // a count of zero means 256 dots
    frame_body.delete();
    frame_body.push_back(CmdDots);
    push_coords(512);
    send_frame(LenW'(frame_body.size()));

    while (bytes_sent < 1800) begin
      quiet = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 19) == 0) drain();
      frame_body.delete();
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        n = $urandom_range(0, 20);
        repeat (n) frame_body.push_back(8'($urandom));
        len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
      end else if (kind < 13) begin
        len = '0;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) add_command();
        case ($urandom_range(0, 2))
          0: len = LenW'(frame_body.size());
          1: begin
            frame_body.push_back(CmdEnd | 8'($urandom_range(0, 15)));
            len = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : LenW'(frame_body.size() + $urandom_range(0, 30));
          end
          default: len = LenW'($urandom_range(1, frame_body.size()));
        endcase
      end
      send_frame(len);
    end

    quiet = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);

    $display("sent %0d bytes in %0d frames; checked %0d results (%0d segments, %0d closes)",
             bytes_sent, frames_sent, sb.checked, sb.segments, sb.closes);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
sv/vcsd_pkg.sv
sv/vector_command_stream_decoder.sv
dv/tb_vector_command_stream_decoder.sv
